@@ design/assembler_token_scanner_top_assert.svh @@
// assertion helpers for the token scanner
`ifndef ASSEMBLER_TOKEN_SCANNER_TOP_ASSERT_SVH
`define ASSEMBLER_TOKEN_SCANNER_TOP_ASSERT_SVH

// same-cycle implication, held off during reset
`define ATS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("token scanner check failed");

// next-cycle implication, held off during reset
`define ATS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("token scanner check failed");

`endif

@@ design/ats_pkg.sv @@
`timescale 1ns / 1ps
package ats_pkg;

    localparam longint MAX_BUFFER = 65536;
    localparam logic [16:0] POS_BOUND =
        (MAX_BUFFER < 64'h1FFFF) ? 17'(MAX_BUFFER) : 17'h1FFFF;
    localparam logic [16:0] LEN_CAP = 17'h10000;

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_HASH       = 8'h23;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_COLON      = 8'h3A;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        KIND_NUMBER  = 3'd0,
        KIND_IDENT   = 3'd1,
        KIND_COLON   = 3'd2,
        KIND_EOF     = 3'd3,
        KIND_INVALID = 3'd4
    } kind_t;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_NUM     = 5'b00010,
        MODE_IDENT   = 5'b00100,
        MODE_COMMENT = 5'b01000,
        MODE_DROP    = 5'b10000
    } mode_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] start;
        logic [16:0] length;
        logic        last_of_run;
    } ats_result_t;

    // results of one byte, first slot filled before second
    typedef struct packed {
        logic [1:0]  n;
        ats_result_t r0;
        ats_result_t r1;
    } ats_push_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_ident_char(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) ||
               ((c >= 8'h41) && (c <= 8'h5A)) || (c == CH_UNDERSCORE);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic [15:0] sat_start(input logic [16:0] p);
        return (p > 17'h0FFFF) ? 16'hFFFF : p[15:0];
    endfunction

    function automatic logic [16:0] token_len(input logic [16:0] e, input logic [15:0] s);
        logic [16:0] d;
        d = (e >= {1'b0, s}) ? (e - {1'b0, s}) : 17'd0;
        return (d > LEN_CAP) ? LEN_CAP : d;
    endfunction

endpackage

@@ design/ats_scan.sv @@
`timescale 1ns / 1ps
`include "assembler_token_scanner_top_assert.svh"
module ats_scan (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  logic [7:0]        ch,
    input  logic              last,
    input  logic              room,
    output ats_pkg::ats_push_t push
);
    import ats_pkg::*;

    logic        in_vld_reg, in_vld_next;
    logic [7:0]  ch_reg;
    logic        last_reg;
    mode_t       mode_reg, mode_next;
    logic [15:0] ts_reg, ts_next;
    logic [16:0] pos_reg, pos_next;
    logic        skip_reg, skip_next;

    logic        adv;
    logic [16:0] endp;
    logic        cont;
    logic        f_hit, c_hit, e_hit;
    ats_result_t f_res, c_res, e_res;
    ats_result_t r0, r1;
    logic [1:0]  n;

    assign adv         = in_vld_reg && room;
    assign byte_stall  = in_vld_reg && !room;
    assign in_vld_next = byte_stall ? in_vld_reg : byte_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    // byte holding register
    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            ch_reg   <= ch;
            last_reg <= last;
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        ts_next   = ts_reg;
        pos_next  = pos_reg;
        skip_next = skip_reg;
        f_hit     = 1'b0;
        c_hit     = 1'b0;
        e_hit     = 1'b0;
        f_res     = '0;
        c_res     = '0;
        e_res     = '0;
        endp      = (pos_reg >= POS_BOUND) ? POS_BOUND : (pos_reg + 17'd1);
        cont      = ((mode_reg == MODE_NUM) && is_digit(ch_reg)) ||
                    ((mode_reg == MODE_IDENT) && is_ident_char(ch_reg));

        unique case (mode_reg)
            MODE_COMMENT:
            begin
                if (ch_reg == CH_NEWLINE)
                begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_DROP:
            begin
                mode_next = MODE_DROP;
            end
            MODE_IDLE, MODE_NUM, MODE_IDENT:
            begin
                if (!cont)
                begin
                    if ((mode_reg == MODE_NUM) || (mode_reg == MODE_IDENT))
                    begin
                        // token ended by this byte
                        f_hit        = 1'b1;
                        f_res.kind   = (mode_reg == MODE_NUM) ? KIND_NUMBER : KIND_IDENT;
                        f_res.start  = ts_reg;
                        f_res.length = token_len(pos_reg, ts_reg);
                        mode_next    = MODE_IDLE;
                        skip_next    = 1'b0;
                    end
                    priority if (is_space(ch_reg))
                    begin
                        skip_next = 1'b1;
                    end
                    else if (ch_reg == CH_HASH)
                    begin
                        mode_next = MODE_COMMENT;
                        skip_next = 1'b1;
                    end
                    else if (is_digit(ch_reg))
                    begin
                        mode_next = MODE_NUM;
                        ts_next   = sat_start(pos_reg);
                    end
                    else if (is_ident_char(ch_reg))
                    begin
                        mode_next = MODE_IDENT;
                        ts_next   = sat_start(pos_reg);
                    end
                    else if (ch_reg == CH_COLON)
                    begin
                        c_hit        = 1'b1;
                        c_res.kind   = KIND_COLON;
                        c_res.start  = sat_start(pos_reg);
                        c_res.length = 17'd1;
                        skip_next    = 1'b0;
                    end
                    else
                    begin
                        c_hit        = 1'b1;
                        c_res.kind   = KIND_INVALID;
                        c_res.start  = sat_start(pos_reg);
                        c_res.length = 17'd1;
                        mode_next    = MODE_DROP;
                    end
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase

        if (last_reg)
        begin
            if ((mode_next == MODE_NUM) || (mode_next == MODE_IDENT))
            begin
                e_hit        = 1'b1;
                e_res.kind   = (mode_next == MODE_NUM) ? KIND_NUMBER : KIND_IDENT;
                e_res.start  = ts_next;
                e_res.length = token_len(endp, ts_next);
            end
            else if ((mode_next != MODE_DROP) && skip_next)
            begin
                e_hit        = 1'b1;
                e_res.kind   = KIND_EOF;
                e_res.start  = sat_start(endp);
                e_res.length = 17'd0;
            end
            mode_next = MODE_IDLE;
            ts_next   = 16'd0;
            pos_next  = 17'd0;
            skip_next = 1'b0;
        end
        else
        begin
            pos_next = endp;
        end
    end

    // pack the up to two results into slot order
    always_comb
    begin
        r0 = f_hit ? f_res : (c_hit ? c_res : e_res);
        r1 = (f_hit && c_hit) ? c_res : e_res;
        n  = 2'({1'b0, f_hit} + {1'b0, c_hit} + {1'b0, e_hit});
        r0.last_of_run = (n == 2'd1);
        r1.last_of_run = 1'b1;
    end

    assign push.n  = adv ? n : 2'd0;
    assign push.r0 = r0;
    assign push.r1 = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            ts_reg   <= 16'd0;
            pos_reg  <= 17'd0;
            skip_reg <= 1'b0;
        end
        else if (adv)
        begin
            mode_reg <= mode_next;
            ts_reg   <= ts_next;
            pos_reg  <= pos_next;
            skip_reg <= skip_next;
        end
    end

    `ATS_ASSERT_IMPL(a_pos_bound, 1'b1, pos_reg <= POS_BOUND)
    `ATS_ASSERT_IMPL(a_start_in_token,
        (mode_reg == MODE_NUM) || (mode_reg == MODE_IDENT), {1'b0, ts_reg} <= pos_reg)
    `ATS_ASSERT_IMPL(a_drop_silent, adv && (mode_reg == MODE_DROP), push.n == 2'd0)
    `ATS_ASSERT_IMPL(a_two_results, push.n == 2'd2, f_hit && (c_hit || e_hit))
    `ATS_ASSERT_NEXT(a_last_restarts, adv && last_reg, pos_reg == 17'd0)

endmodule

@@ design/ats_result_fifo.sv @@
`timescale 1ns / 1ps
module ats_result_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  ats_pkg::ats_push_t push,
    output logic              room,
    output logic              token_valid,
    input  logic              token_stall,
    output logic [2:0]        kind,
    output logic [15:0]       start_res,
    output logic [16:0]       length,
    output logic              last_of_run
);
    import ats_pkg::*;

    ats_result_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]        wr_reg, wr_next;
    logic [FIFO_AW-1:0]        rd_reg, rd_next;
    logic [FIFO_CW-1:0]        cnt_reg, cnt_next;
    logic                      pop;
    ats_result_t               head;

    assign token_valid = (cnt_reg != '0);
    assign pop         = token_valid && !token_stall;
    // room for a full pair of results from one byte
    assign room        = (cnt_reg <= FIFO_CW'(FIFO_DEPTH - 2));

    assign wr_next  = wr_reg + FIFO_AW'(push.n);
    assign rd_next  = rd_reg + FIFO_AW'(pop);
    assign cnt_next = cnt_reg + FIFO_CW'(push.n) - FIFO_CW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            mem_reg[wr_reg] <= push.r0;
        end
        if (push.n == 2'd2)
        begin
            mem_reg[wr_reg + FIFO_AW'(1)] <= push.r1;
        end
    end

    assign head        = mem_reg[rd_reg];
    assign kind        = head.kind;
    assign start_res   = head.start;
    assign length      = head.length;
    assign last_of_run = head.last_of_run;

endmodule

@@ design/assembler_token_scanner_top.sv @@
// path: an accepted byte is held in the byte register, then its results are written into the result queue
// throughput: one byte per cycle while each byte yields at most one result and the output does
// not stall; results leave one at a time, and the four-entry result queue absorbs bursts
// reset: rst_n is asynchronous and active low, it empties the byte register and the result
// queue and returns the scanner to idle at offset zero
`timescale 1ns / 1ps
module assembler_token_scanner_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  ch,
    input  logic        last,
    output logic        token_valid,
    input  logic        token_stall,
    output logic [2:0]  kind,
    output logic [15:0] start_res,
    output logic [16:0] length,
    output logic        last_of_run
);
    import ats_pkg::*;

    // results of one byte, handed from the scanner to the queue
    ats_push_t push;
    // queue can take a full pair of results this cycle
    logic      room;

    // byte register, mode and offset state and the classification logic;
    // the scanner moves a byte on only when the queue has space for two results
    ats_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .ch         (ch),
        .last       (last),
        .room       (room),
        .push       (push)
    );

    // result queue, parts the scanner from the downstream stall so that a
    // waiting token does not hold back the next byte
    ats_result_fifo u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .room        (room),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .kind        (kind),
        .start_res   (start_res),
        .length      (length),
        .last_of_run (last_of_run)
    );

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import ats_pkg::*;

    // output hold-off length used to back the scanner up
    localparam int HOLD_CYCLES   = 200;
    // idle cycles allowed after the last expected token
    localparam int SETTLE_CYCLES = 20;
    // rough number of random source bytes
    localparam int RANDOM_BYTES  = 370;
    // only the first few mismatches are printed in full
    localparam int REPORT_LIMIT  = 10;
    // colons sent while the output is held off
    localparam int HOLD_COLONS   = 40;

    // first 53 characters may open an identifier, the digits only continue one
    localparam string WORD_CHARS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZ_abcdefghijklmnopqrstuvwxyz0123456789";

    typedef struct {
        logic [7:0] code;
        logic       mark;
    } src_byte_t;

    // dut ports, every input known from time zero
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        byte_valid  = 1'b0;
    logic        byte_stall;
    logic [7:0]  ch          = 8'h00;
    logic        last        = 1'b0;
    logic        token_valid;
    logic        token_stall = 1'b0;
    logic [2:0]  kind;
    logic [15:0] start_res;
    logic [16:0] length;
    logic        last_of_run;

    // source bytes still to be offered, and tokens still to arrive
    src_byte_t   byte_queue[$];
    ats_result_t token_expect[$];

    // scanner state as the testbench sees it
    mode_t       scan_state = MODE_IDLE;
    logic [15:0] tok_begin  = 16'd0;
    logic [16:0] cur_pos    = 17'd0;
    logic        gap_seen   = 1'b0;

    // handshake bookkeeping
    logic        byte_accepted = 1'b0;
    int          send_gap      = 0;
    int          recv_gap      = 0;
    logic        sender_idle_en = 1'b1;
    logic        recv_idle_en   = 1'b1;
    logic        hold_req       = 1'b0;
    logic        hold_on        = 1'b0;

    // run statistics
    int          bytes_queued  = 0;
    int          bytes_taken   = 0;
    int          buffers_done  = 0;
    int          tokens_seen   = 0;
    int          mismatches    = 0;

    assembler_token_scanner_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .ch          (ch),
        .last        (last),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .kind        (kind),
        .start_res   (start_res),
        .length      (length),
        .last_of_run (last_of_run)
    );

    // 2 ns clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // character classes
    // ---------------------------------------------------------------
    function automatic logic numeral(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic word_char(input logic [7:0] c);
        return numeral(c) || ((c >= "a") && (c <= "z")) ||
               ((c >= "A") && (c <= "Z")) || (c == CH_UNDERSCORE);
    endfunction

    function automatic logic blank(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // offsets beyond 16 bits pin to the top value
    function automatic logic [15:0] clip_start(input logic [17:0] p);
        return (p > 18'h0FFFF) ? 16'hFFFF : p[15:0];
    endfunction

    // ---------------------------------------------------------------
    // token prediction
    // ---------------------------------------------------------------
    function automatic void push_token(input kind_t k, input logic [17:0] s,
                                       input logic [17:0] n);
        ats_result_t tok;
        tok.kind        = k;
        tok.start       = clip_start(s);
        tok.length      = (n > {1'b0, LEN_CAP}) ? LEN_CAP : n[16:0];
        tok.last_of_run = 1'b0;
        token_expect.push_back(tok);
    endfunction

    // report the number or identifier that ends at offset e
    function automatic void close_word(input logic [17:0] e);
        logic [17:0] n;
        n = (e >= {2'b00, tok_begin}) ? e - {2'b00, tok_begin} : 18'd0;
        push_token((scan_state == MODE_NUM) ? KIND_NUMBER : KIND_IDENT,
                   {2'b00, tok_begin}, n);
    endfunction

    // advance the scanner by one accepted source byte
    function automatic void scan_byte(input logic [7:0] c, input logic fin);
        logic [17:0] here;
        logic [17:0] after;
        int          queued_cnt;
        logic        run_on;
        ats_result_t tail;
        here       = {1'b0, cur_pos};
        after      = here + 18'd1;
        if (after > {1'b0, POS_BOUND})
            after = {1'b0, POS_BOUND};
        queued_cnt = token_expect.size();

        if (scan_state == MODE_COMMENT)
        begin
            if (c == CH_NEWLINE)
                scan_state = MODE_IDLE;
        end
        else if (scan_state != MODE_DROP)
        begin
            run_on = ((scan_state == MODE_NUM) && numeral(c)) ||
                     ((scan_state == MODE_IDENT) && word_char(c));
            if (!run_on)
            begin
                // the byte after a token closes it, then is scanned afresh
                if ((scan_state == MODE_NUM) || (scan_state == MODE_IDENT))
                begin
                    close_word(here);
                    scan_state = MODE_IDLE;
                    gap_seen   = 1'b0;
                end
                if (blank(c))
                    gap_seen = 1'b1;
                else if (c == CH_HASH)
                begin
                    scan_state = MODE_COMMENT;
                    gap_seen   = 1'b1;
                end
                else if (numeral(c))
                begin
                    scan_state = MODE_NUM;
                    tok_begin  = clip_start(here);
                end
                else if (word_char(c))
                begin
                    scan_state = MODE_IDENT;
                    tok_begin  = clip_start(here);
                end
                else if (c == CH_COLON)
                begin
                    push_token(KIND_COLON, here, 18'd1);
                    gap_seen = 1'b0;
                end
                else
                begin
                    // bad byte, the rest of the buffer is thrown away
                    push_token(KIND_INVALID, here, 18'd1);
                    scan_state = MODE_DROP;
                end
            end
        end

        if (fin)
        begin
            if ((scan_state == MODE_NUM) || (scan_state == MODE_IDENT))
                close_word(after);
            else if ((scan_state != MODE_DROP) && gap_seen)
                push_token(KIND_EOF, after, 18'd0);
            scan_state = MODE_IDLE;
            tok_begin  = 16'd0;
            cur_pos    = 17'd0;
            gap_seen   = 1'b0;
        end
        else
            cur_pos = after[16:0];

        if (token_expect.size() > queued_cnt)
        begin
            tail             = token_expect.pop_back();
            tail.last_of_run = 1'b1;
            token_expect.push_back(tail);
        end
    endfunction

    // ---------------------------------------------------------------
    // stimulus building
    // ---------------------------------------------------------------
    task automatic add_byte(input logic [7:0] c, input logic mark);
        src_byte_t b;
        b.code = c;
        b.mark = mark;
        byte_queue.push_back(b);
        bytes_queued++;
    endtask

    task automatic add_text(input string s, input logic mark);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i], mark && (i == s.len() - 1));
    endtask

    // one buffer made of mostly well-formed pieces with some noise
    task automatic add_random_buffer();
        logic [7:0] text[$];
        logic [7:0] c;
        int         pieces;
        int         n;
        int         k;
        pieces = $urandom_range(1, 8);
        repeat (pieces)
        begin
            case ($urandom_range(0, 17))
                0, 1, 2, 3:
                begin
                    n = $urandom_range(1, 5);
                    repeat (n)
                        text.push_back(8'("0" + $urandom_range(0, 9)));
                end
                4, 5, 6, 7:
                begin
                    text.push_back(WORD_CHARS[$urandom_range(0, 52)]);
                    n = $urandom_range(0, 6);
                    repeat (n)
                        text.push_back(WORD_CHARS[$urandom_range(0, WORD_CHARS.len() - 1)]);
                end
                8, 9:
                    text.push_back(CH_COLON);
                10, 11, 12, 13:
                begin
                    n = $urandom_range(1, 3);
                    repeat (n)
                    begin
                        k = $urandom_range(8, 13);
                        text.push_back((k == 8) ? 8'h20 : 8'(k));
                    end
                end
                14, 15:
                begin
                    // comment body may hold any byte but a newline
                    text.push_back(CH_HASH);
                    n = $urandom_range(0, 6);
                    repeat (n)
                    begin
                        do
                            c = 8'($urandom_range(0, 255));
                        while (c == CH_NEWLINE);
                        text.push_back(c);
                    end
                    if ($urandom_range(0, 3) != 0)
                        text.push_back(CH_NEWLINE);
                end
                16:
                begin
                    do
                        c = 8'($urandom_range(0, 255));
                    while (numeral(c) || word_char(c) || blank(c) ||
                           (c == CH_HASH) || (c == CH_COLON));
                    text.push_back(c);
                end
                default:
                    text.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        for (int i = 0; i < text.size(); i++)
            add_byte(text[i], i == text.size() - 1);
    endtask

    // hold the source back until every issued byte and token is done
    task automatic drain();
        while ((bytes_taken != bytes_queued) || (token_expect.size() != 0))
            @(negedge clk);
    endtask

    // ---------------------------------------------------------------
    // source driver: new transaction on the falling edge once the last
    // one has gone, payload held steady while stalled
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        src_byte_t next_byte;
        if (!rst_n)
            byte_valid <= 1'b0;
        else if (!byte_valid || byte_accepted)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                byte_valid <= 1'b0;
            end
            else if (byte_queue.size() == 0)
                byte_valid <= 1'b0;
            else if (sender_idle_en && ($urandom_range(0, 7) == 0))
            begin
                // idle burst that starts with this cycle
                send_gap   = $urandom_range(0, 14);
                byte_valid <= 1'b0;
            end
            else
            begin
                next_byte  = byte_queue.pop_front();
                byte_valid <= 1'b1;
                ch         <= next_byte.code;
                last       <= next_byte.mark;
            end
        end
    end

    // ---------------------------------------------------------------
    // token receiver: random stall bursts, or the long hold-off
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_on)
            token_stall <= 1'b1;
        else if (recv_gap > 0)
        begin
            recv_gap--;
            token_stall <= 1'b1;
        end
        else if (recv_idle_en && ($urandom_range(0, 7) == 0))
        begin
            recv_gap    = $urandom_range(0, 14);
            token_stall <= 1'b1;
        end
        else
            token_stall <= 1'b0;
    end

    // long output hold-off, counted here so the sender keeps going meanwhile
    initial
    begin
        wait (hold_req);
        @(posedge clk);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on = 1'b0;
    end

    // ---------------------------------------------------------------
    // monitor: check each token transaction against the oldest
    // prediction, then feed the accepted source byte to the predictor
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        ats_result_t want;
        if (!rst_n)
            byte_accepted <= 1'b0;
        else
        begin
            byte_accepted <= byte_valid && !byte_stall;

            if (token_valid && !token_stall)
            begin
                tokens_seen++;
                if (token_expect.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected token: kind %0d start %0d len %0d last %0b",
                                 kind, start_res, length, last_of_run);
                end
                else
                begin
                    want = token_expect.pop_front();
                    if ((kind !== want.kind) || (start_res !== want.start) ||
                        (length !== want.length) || (last_of_run !== want.last_of_run))
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $display("token %0d mismatch: expected kind %0d start %0d len %0d last %0b",
                                     tokens_seen, want.kind, want.start, want.length,
                                     want.last_of_run);
                            $display("    got kind %0d start %0d len %0d last %0b",
                                     kind, start_res, length, last_of_run);
                        end
                    end
                end
            end

            if (byte_valid && !byte_stall)
            begin
                bytes_taken++;
                if (last)
                    buffers_done++;
                scan_byte(ch, last);
            end
        end
    end

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial
    begin
        int random_from;

        // directed buffers, queued before reset is released
        // number cut by a letter, then identifier and colon on one byte
        add_text("9a_Z:", 1'b1);
        // every whitespace byte, a number, a comment closed by newline, eof
        for (int i = 9; i <= 13; i++)
            add_byte(8'(i), 1'b0);
        add_text(" 0 #z", 1'b0);
        add_byte(CH_NEWLINE, 1'b1);
        // nul after an identifier, the rest of the buffer dropped
        add_text("A", 1'b0);
        add_byte(8'h00, 1'b0);
        add_text("b", 1'b1);
        // top byte value alone
        add_byte(8'hFF, 1'b1);
        // comment open at end of buffer gives eof
        add_byte(CH_HASH, 1'b1);
        // identifier still pending at the end mark
        add_text("_1", 1'b1);

        // reset held from time zero, released on a falling edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // source pauses until all directed tokens have come back
        drain();

        // random buffers with idling on both sides
        random_from = bytes_queued;
        while (bytes_queued - random_from < RANDOM_BYTES)
            add_random_buffer();
        drain();

        // hold the output off while colons stream in, so the scanner backs up
        sender_idle_en = 1'b0;
        recv_idle_en   = 1'b0;
        hold_req       = 1'b1;
        for (int i = 0; i < HOLD_COLONS; i++)
            add_byte(CH_COLON, i == HOLD_COLONS - 1);
        drain();

        // last part, no idling: tokens back to back, at most one result per byte
        add_text("x_1 42\t:9", 1'b0);
        add_text("77 :#q", 1'b1);
        drain();

        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("scanned %0d bytes in %0d buffers, %0d tokens compared",
                 bytes_taken, buffers_done, tokens_seen);
        $display("included directed cases, random buffers and an output hold-off");
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

endmodule

@@ assembler_token_scanner_top.f @@
+incdir+design
design/ats_pkg.sv
design/ats_scan.sv
design/ats_result_fifo.sv
design/assembler_token_scanner_top.sv
tb/sv/testbench.sv
